/* src/apcd_pkg.sv */
// ============================================================================
// apcd_pkg: shared definitions for the allpass cascade disperser
// Sample and coefficient formats, the history entry layout and register codes.
// ============================================================================
package apcd_pkg;

	localparam int SECTION_MAX    = 64;
	localparam int SEC_AW         = $clog2(SECTION_MAX);
	localparam int SEC_CW         = $clog2(SECTION_MAX + 1);
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_BITS      = 32;
	localparam int COEF_FRAC_BITS = 29;
	localparam int FRAC_SHIFT     = COEF_FRAC_BITS - (SAMPLE_BITS - 1);
	localparam int MUL_B_BITS     = SAMPLE_BITS + 1;
	localparam int PROD_BITS      = COEF_BITS + MUL_B_BITS;
	localparam int ACC_BITS       = PROD_BITS + 3;
	localparam int WHOLE_BITS     = 7;
	localparam int FRAC_BITS      = 16;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 32;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	// One history entry per section: last two inputs and last two outputs.
	typedef struct packed {
		sample_t x1;
		sample_t x2;
		sample_t y1;
		sample_t y2;
	} hist_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DIRECT   = 2'd0,
		REG_COSINE   = 2'd1,
		REG_WHOLE    = 2'd2,
		REG_FRACTION = 2'd3
	} cfg_reg_t;

endpackage

/* src/apcd_hist_mem.sv */
// ============================================================================
// apcd_hist_mem: section history memory
// One entry per section, one read and one write port, registered read data.
// Entries never written since reset read as zero through per-entry valid bits.
// ============================================================================
module apcd_hist_mem import apcd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [SEC_AW-1:0] rd_addr,
	output hist_t             rd_data,
	input  logic              wr_en,
	input  logic [SEC_AW-1:0] wr_addr,
	input  hist_t             wr_data
);

	hist_t                  mem [SECTION_MAX];
	hist_t                  rd_data_q;
	logic                   rd_valid_q;
	logic [SECTION_MAX-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

/* src/allpass_cascade_disperser_top.sv */
// ============================================================================
// allpass_cascade_disperser_top: cascaded second-order allpass filter
// Runs each sample through up to 64 identical allpass sections with one shared
// multiplier, plus an optional partial section blended in by a fraction.
// ============================================================================
//
// Channel   Handshake                Payload
// -------   ----------------------   ----------------------------------------
// in        in_valid / in_ready      sample_in   (24, signed Q1.23)
// out       out_valid / out_ready    sample_out  (24, signed Q1.23)
// cfg       cfg_we (no wait)         cfg_index (2), cfg_data (32)
//
// Each section runs its multiply-accumulate steps on the shared 32x25
// multiplier and accumulator, then rounds, saturates and writes the history
// back. The history memory needs no clearing pass after reset. in_ready is
// high only between samples; a finished result waits in the output register
// while the next sample is accepted.
module allpass_cascade_disperser_top import apcd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [23:0]       sample_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [23:0]       sample_out
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MAC    = 6'b000010,
		ST_WB     = 6'b000100,
		ST_BL_MUL = 6'b001000,
		ST_BL_ADD = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;
	localparam logic signed [ACC_BITS-1:0] SEC_ROUND = ACC_BITS'(64'sd1 <<< (FRAC_SHIFT - 1));
	localparam logic signed [ACC_BITS-1:0] BL_ROUND = ACC_BITS'(64'sd1 <<< (FRAC_BITS - 1));

	function automatic sample_t sat_acc(input logic signed [ACC_BITS-1:0] v);
		sample_t r;
		if (v > SAT_HI) begin
			r = SAT_HI[SAMPLE_BITS-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			r = v[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [ACC_BITS-1:0] ext_sample(input sample_t s);
		return {{(ACC_BITS-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
	endfunction

	// Configuration registers.
	logic signed [COEF_BITS-1:0] c0_q;
	logic signed [COEF_BITS-1:0] c1_q;
	logic [WHOLE_BITS-1:0]       whole_q;
	logic [FRAC_BITS-1:0]        frac_q;

	// Sequencer and datapath registers.
	state_t                      state_q;
	logic [2:0]                  step_q;
	logic [SEC_CW-1:0]           k_q;
	logic [SEC_CW-1:0]           n_q;
	logic                        partial_q;
	logic                        in_partial_q;
	sample_t                     x_q;
	sample_t                     y_q;
	sample_t                     res_q;
	logic signed [PROD_BITS-1:0] prod_q;
	logic signed [ACC_BITS-1:0]  acc_q;
	logic                        out_valid_q;
	sample_t                     sample_out_q;

	// Combinational signals.
	hist_t                        hist;
	hist_t                        wr_data;
	logic                         accept;
	logic                         rd_en;
	logic [SEC_AW-1:0]            rd_addr;
	logic                         wr_en;
	logic [SEC_CW-1:0]            k_next;
	logic [SEC_CW-1:0]            n_eff;
	logic signed [COEF_BITS-1:0]  mul_a;
	logic signed [MUL_B_BITS-1:0] mul_b;
	logic signed [MUL_B_BITS-1:0] diff;
	logic signed [ACC_BITS-1:0]   prod_ext;
	logic signed [ACC_BITS-1:0]   acc_shr;
	logic signed [ACC_BITS-1:0]   blend_sum;
	sample_t                      sec_y;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	assign k_next = k_q + SEC_CW'(1);

	always_comb begin
		if (whole_q == '0) begin
			n_eff = SEC_CW'(1);
		end else if (SEC_CW'(whole_q) > SEC_CW'(SECTION_MAX)) begin
			n_eff = SEC_CW'(SECTION_MAX);
		end else begin
			n_eff = SEC_CW'(whole_q);
		end
	end

	// History memory: the write of section k and the prefetch of section k+1
	// happen in the same write-back cycle.
	assign rd_en   = accept || (state_q == ST_WB);
	assign rd_addr = (state_q == ST_WB) ? k_next[SEC_AW-1:0] : '0;
	assign wr_en   = (state_q == ST_WB);
	assign wr_data = '{x1: x_q, x2: hist.x1, y1: sec_y, y2: hist.y1};

	apcd_hist_mem u_hist_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (hist),
		.wr_en   (wr_en),
		.wr_addr (k_q[SEC_AW-1:0]),
		.wr_data (wr_data)
	);

	assign diff = {y_q[SAMPLE_BITS-1], y_q} - {x_q[SAMPLE_BITS-1], x_q};

	// Shared multiplier operands. The last two products are subtracted.
	always_comb begin
		if (state_q == ST_BL_MUL) begin
			mul_a = {{(COEF_BITS-FRAC_BITS){1'b0}}, frac_q};
			mul_b = diff;
		end else begin
			case (step_q)
				3'd0: begin
					mul_a = c0_q;
					mul_b = {x_q[SAMPLE_BITS-1], x_q};
				end
				3'd1: begin
					mul_a = c1_q;
					mul_b = {hist.x1[SAMPLE_BITS-1], hist.x1};
				end
				3'd2: begin
					mul_a = c1_q;
					mul_b = {hist.y1[SAMPLE_BITS-1], hist.y1};
				end
				default: begin
					mul_a = c0_q;
					mul_b = {hist.y2[SAMPLE_BITS-1], hist.y2};
				end
			endcase
		end
	end

	assign prod_ext  = {{(ACC_BITS-PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};
	assign acc_shr   = acc_q >>> FRAC_SHIFT;
	assign sec_y     = sat_acc(acc_shr);
	assign blend_sum = ext_sample(x_q) + ((prod_ext + BL_ROUND) >>> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c0_q    <= '0;
			c1_q    <= '0;
			whole_q <= WHOLE_BITS'(1);
			frac_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DIRECT:   c0_q    <= cfg_data;
				REG_COSINE:   c1_q    <= cfg_data;
				REG_WHOLE:    whole_q <= cfg_data[WHOLE_BITS-1:0];
				REG_FRACTION: frac_q  <= cfg_data[FRAC_BITS-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			k_q          <= '0;
			n_q          <= SEC_CW'(1);
			partial_q    <= 1'b0;
			in_partial_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// A new result may replace the one leaving in the same cycle.
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q       <= '0;
						k_q          <= '0;
						n_q          <= n_eff;
						partial_q    <= (frac_q != '0) && (n_eff < SEC_CW'(SECTION_MAX));
						in_partial_q <= 1'b0;
						state_q      <= ST_MAC;
					end
				end
				ST_MAC: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					step_q <= '0;
					k_q    <= k_next;
					if (!in_partial_q && (k_next < n_q)) begin
						state_q <= ST_MAC;
					end else if (!in_partial_q && partial_q) begin
						in_partial_q <= 1'b1;
						state_q      <= ST_MAC;
					end else if (in_partial_q) begin
						state_q <= ST_BL_MUL;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_BL_MUL: begin
					state_q <= ST_BL_ADD;
				end
				ST_BL_ADD: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= sample_in;
		end
		if ((state_q == ST_MAC && step_q != 3'd4) || state_q == ST_BL_MUL) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == ST_MAC) begin
			if (step_q == 3'd0) begin
				acc_q <= (ext_sample(hist.x2) <<< COEF_FRAC_BITS) + SEC_ROUND;
			end else if (step_q >= 3'd3) begin
				acc_q <= acc_q - prod_ext;
			end else begin
				acc_q <= acc_q + prod_ext;
			end
		end
		if (state_q == ST_WB) begin
			y_q <= sec_y;
			if (!in_partial_q) begin
				x_q <= sec_y;
			end
			if (!in_partial_q && !(k_next < n_q) && !partial_q) begin
				res_q <= sec_y;
			end
		end
		if (state_q == ST_BL_ADD) begin
			res_q <= sat_acc(blend_sum);
		end
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			sample_out_q <= res_q;
		end
	end

	// The multiply-accumulate step counter never runs past its last step.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC |-> step_q <= 3'd4)
		else $error("MAC step counter out of range");

	// Only whole sections below the count, or the single partial section, are written back.
	a_section_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WB |-> (k_q < n_q) || (in_partial_q && k_q == n_q))
		else $error("section index beyond the active chain");

	// Blending happens only after the partial section of a sample that asked for one.
	a_blend_partial: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BL_MUL |-> partial_q && in_partial_q)
		else $error("blend without a partial section");

	// A new result appears only from the hand-off state.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("output became valid outside the hand-off state");

endmodule
